/* rtl/spc_pkg.sv */
// spc_pkg: shared constants, control word types and the microcode rom of the
// sieve prime counter. No dependencies.
package spc_pkg;

    // bitmap size and derived widths
    localparam int TABLE_ENTRIES = 1048576;
    localparam int MAP_AW        = $clog2(TABLE_ENTRIES);
    localparam int NUM_W         = MAP_AW + 1;          // holds bound plus a factor
    localparam int F_W           = (MAP_AW + 1) / 2 + 1; // factor up to sqrt(bound)+1
    localparam int SQ_W          = 2 * F_W;
    localparam int FIELD_W       = 20;                   // input field width
    localparam int CMP_W         = 25;                   // compare width, wider than every operand compared here
    localparam int CNT_W         = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // microcode address
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t PC_IDLE  = 4'd0;
    localparam upc_t PC_CHECK = 4'd1;
    localparam upc_t PC_CLEAR = 4'd2;
    localparam upc_t PC_FINIT = 4'd3;
    localparam upc_t PC_SQR   = 4'd4;
    localparam upc_t PC_FTEST = 4'd5;
    localparam upc_t PC_FWAIT = 4'd6;
    localparam upc_t PC_MARK  = 4'd7;
    localparam upc_t PC_FNEXT = 4'd8;
    localparam upc_t PC_CINIT = 4'd9;
    localparam upc_t PC_CREAD = 4'd10;
    localparam upc_t PC_CLAST = 4'd11;
    localparam upc_t PC_OUT   = 4'd12;
    localparam upc_t PC_DONE  = 4'd13;

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_IDLE,    // take an item, load bounds
        OP_CLEAR,   // write 0 at n, n++
        OP_FINIT,   // f = 2
        OP_SQUARE,  // sq = f*f
        OP_FREAD,   // read map at f
        OP_MINIT,   // m = sq
        OP_MARK,    // write 1 at m, m += f
        OP_FINC,    // f++
        OP_CINIT,   // n = lo
        OP_CREAD,   // read map at n, n++
        OP_EMIT     // load the result register
    } op_t;

    // jump condition: jump to target when true, else fall through
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ACCEPT,
        COND_HI_LT2,
        COND_CLR_MORE,
        COND_SQ_GT_HI,
        COND_COMPOSITE,
        COND_MARK_MORE,
        COND_LO_GT_HI,
        COND_CNT_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // status flags from the datapath to the sequencer
    typedef struct packed {
        logic no_accept;
        logic hi_lt2;
        logic clr_more;
        logic sq_gt_hi;
        logic composite;
        logic mark_more;
        logic lo_gt_hi;
        logic cnt_more;
        logic out_busy;
    } flags_t;

    // the program
    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        case (pc)
            PC_IDLE:  w = '{OP_IDLE,   COND_NO_ACCEPT, PC_IDLE};
            PC_CHECK: w = '{OP_NONE,   COND_HI_LT2,    PC_OUT};
            PC_CLEAR: w = '{OP_CLEAR,  COND_CLR_MORE,  PC_CLEAR};
            PC_FINIT: w = '{OP_FINIT,  COND_NEVER,     PC_IDLE};
            PC_SQR:   w = '{OP_SQUARE, COND_NEVER,     PC_IDLE};
            PC_FTEST: w = '{OP_FREAD,  COND_SQ_GT_HI,  PC_CINIT};
            PC_FWAIT: w = '{OP_MINIT,  COND_COMPOSITE, PC_FNEXT};
            PC_MARK:  w = '{OP_MARK,   COND_MARK_MORE, PC_MARK};
            PC_FNEXT: w = '{OP_FINC,   COND_ALWAYS,    PC_SQR};
            PC_CINIT: w = '{OP_CINIT,  COND_LO_GT_HI,  PC_OUT};
            PC_CREAD: w = '{OP_CREAD,  COND_CNT_MORE,  PC_CREAD};
            PC_CLAST: w = '{OP_NONE,   COND_NEVER,     PC_IDLE};
            PC_OUT:   w = '{OP_EMIT,   COND_OUT_BUSY,  PC_OUT};
            PC_DONE:  w = '{OP_NONE,   COND_ALWAYS,    PC_IDLE};
            default:  w = '{OP_NONE,   COND_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/spc_ram.sv */
// spc_ram: generic single-port ram with registered read.
// No dependencies.
module spc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write when enabled, and registered read of the addressed word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/spc_useq.sv */
// spc_useq: microcode sequencer, step counter plus conditional jumps over
// the program in spc_pkg.
module spc_useq (
    input  logic            aclk,
    input  logic            aresetn,
    input  spc_pkg::flags_t flags,
    output spc_pkg::uword_t uword
);
    import spc_pkg::*;

    upc_t pc_reg, pc_next;
    logic take;

    assign uword = ucode_rom(pc_reg);

    // condition select
    always_comb begin
        case (uword.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_ACCEPT: take = flags.no_accept;
            COND_HI_LT2:    take = flags.hi_lt2;
            COND_CLR_MORE:  take = flags.clr_more;
            COND_SQ_GT_HI:  take = flags.sq_gt_hi;
            COND_COMPOSITE: take = flags.composite;
            COND_MARK_MORE: take = flags.mark_more;
            COND_LO_GT_HI:  take = flags.lo_gt_hi;
            COND_CNT_MORE:  take = flags.cnt_more;
            COND_OUT_BUSY:  take = flags.out_busy;
            default:        take = 1'b1;
        endcase
        pc_next = take ? uword.target : upc_t'(pc_reg + 1'b1);
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/sieve_prime_counter.sv */
// sieve_prime_counter: top level, datapath around a one-bit bitmap ram.
// Depends on spc_pkg, spc_useq and spc_ram.

// Counts the primes in [max(range_low,2), min(range_high, TABLE_ENTRIES-1)]
// with the sieve of Eratosthenes and returns one count per item. One item is
// worked at a time; the block takes the next item while the previous result
// still waits on the m_ channel. The work runs on the single-port bitmap ram:
// with hi the clamped upper bound, it clears entries 0 to hi, then marks the
// multiples of each unmarked factor up to sqrt(hi), starting at the factor's
// square, then reads entries lo to hi and counts the unmarked ones.
module sieve_prime_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [spc_pkg::FIELD_W-1:0]   s_range_low,
    input  logic [spc_pkg::FIELD_W-1:0]   s_range_high,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [spc_pkg::CNT_W-1:0]     m_prime_count
);
    import spc_pkg::*;

    uword_t uword;
    flags_t flags;

    logic [NUM_W-1:0]   hi_reg, hi_next;
    logic [FIELD_W-1:0] lo_reg, lo_next;
    logic [NUM_W-1:0]   n_reg, n_next;
    logic [NUM_W-1:0]   m_reg, m_next;
    logic [F_W-1:0]     f_reg, f_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic               accept;
    logic               emit;
    logic [NUM_W-1:0]   hi_clamp;
    logic [NUM_W-1:0]   m_step;
    logic               ram_we;
    logic               ram_wdata;
    logic               ram_rdata;
    logic [MAP_AW-1:0]  ram_addr;

    spc_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    spc_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_ENTRIES)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // handshake
    assign s_ready       = (uword.op == OP_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = out_valid_reg;
    assign m_prime_count = out_cnt_reg;

    // clamp of the upper bound to the table
    assign hi_clamp = (CMP_W'(s_range_high) > CMP_W'(TABLE_ENTRIES - 1))
                      ? NUM_W'(TABLE_ENTRIES - 1) : NUM_W'(s_range_high);

    assign m_step = m_reg + NUM_W'(f_reg);

    // status flags for the sequencer
    always_comb begin
        flags.no_accept = !accept;
        flags.hi_lt2    = (hi_reg < NUM_W'(2));
        flags.clr_more  = (n_reg != hi_reg);
        flags.sq_gt_hi  = (CMP_W'(sq_reg) > CMP_W'(hi_reg));
        flags.composite = ram_rdata;
        flags.mark_more = (m_step <= hi_reg);
        flags.lo_gt_hi  = (CMP_W'(lo_reg) > CMP_W'(hi_reg));
        flags.cnt_more  = (n_reg != hi_reg);
        flags.out_busy  = out_valid_reg && !m_ready;
    end

    // ram port
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        case (uword.op)
            OP_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = n_reg[MAP_AW-1:0];
            end
            OP_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                ram_addr  = m_reg[MAP_AW-1:0];
            end
            OP_FREAD: ram_addr = MAP_AW'(f_reg);
            default:  ram_addr = n_reg[MAP_AW-1:0];
        endcase
    end

    // datapath next values
    always_comb begin
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        n_next   = n_reg;
        m_next   = m_reg;
        f_next   = f_reg;
        sq_next  = sq_reg;
        cnt_next = cnt_reg;
        emit     = 1'b0;

        // a read issued last cycle is counted when it shows an unmarked entry
        if (pend_reg && !ram_rdata && cnt_reg != COUNT_MAX) begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (uword.op)
            OP_IDLE: begin
                if (accept) begin
                    hi_next  = hi_clamp;
                    lo_next  = (s_range_low < FIELD_W'(2)) ? FIELD_W'(2) : s_range_low;
                    n_next   = '0;
                    cnt_next = '0;
                end
            end
            OP_CLEAR:  n_next  = n_reg + 1'b1;
            OP_FINIT:  f_next  = F_W'(2);
            OP_SQUARE: sq_next = f_reg * f_reg;
            OP_MINIT:  m_next  = NUM_W'(sq_reg);
            OP_MARK:   m_next  = m_step;
            OP_FINC:   f_next  = f_reg + 1'b1;
            OP_CINIT:  n_next  = NUM_W'(lo_reg);
            OP_CREAD:  n_next  = n_reg + 1'b1;
            OP_EMIT:   emit    = !flags.out_busy;
            default: begin
            end
        endcase

        // result register
        out_valid_next = out_valid_reg;
        out_cnt_next   = out_cnt_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_cnt_next   = cnt_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= (uword.op == OP_CREAD);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        f_reg       <= f_next;
        sq_reg      <= sq_next;
        cnt_reg     <= cnt_next;
        out_cnt_reg <= out_cnt_next;
    end

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for the sieve prime counter, with a prime-count
// predictor built from its own sieve table and a queue of expected counts.
// Depends on spc_pkg and the rtl of sieve_prime_counter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_range_low = '0;
    logic [FIELD_W-1:0] s_range_high = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CNT_W-1:0]   m_prime_count;

    // predictor tables: composite flags and running prime totals
    bit                 composite_tbl [TABLE_ENTRIES];
    int unsigned        primes_upto [TABLE_ENTRIES];

    logic [CNT_W-1:0]   expected_counts [$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    sieve_prime_counter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_count (m_prime_count)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // sieve over the whole table, then running totals of primes
    function automatic void build_prime_table();
        int unsigned f;
        int unsigned m;
        int unsigned run;
        composite_tbl[0] = 1'b1;
        composite_tbl[1] = 1'b1;
        for (f = 2; f * f < TABLE_ENTRIES; f++) begin
            if (!composite_tbl[f]) begin
                for (m = f * f; m < TABLE_ENTRIES; m += f)
                    composite_tbl[m] = 1'b1;
            end
        end
        run = 0;
        for (m = 0; m < TABLE_ENTRIES; m++) begin
            if (!composite_tbl[m])
                run++;
            primes_upto[m] = run;
        end
    endfunction

    // primes in [max(lo,2), min(hi, table end)], saturated to the field
    function automatic logic [CNT_W-1:0] predict_prime_count(
        input logic [FIELD_W-1:0] lo,
        input logic [FIELD_W-1:0] hi
    );
        longint unsigned top;
        longint unsigned bottom;
        longint unsigned total;
        top = hi;
        bottom = lo;
        if (top > TABLE_ENTRIES - 1)
            top = TABLE_ENTRIES - 1;
        if (bottom < 2)
            bottom = 2;
        if (top < 2 || bottom > top)
            return '0;
        total = primes_upto[top] - primes_upto[bottom - 1];
        if (total > COUNT_MAX)
            total = COUNT_MAX;
        return total[CNT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // receiver: random stalls, changed at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result check against the oldest expected count
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                report_mismatch($sformatf("unexpected count %0d", m_prime_count));
            end else begin
                logic [CNT_W-1:0] want;
                want = expected_counts.pop_front();
                if (m_prime_count !== want)
                    report_mismatch($sformatf("prime_count %0d, expected %0d",
                                              m_prime_count, want));
            end
        end
    end

    // send one range item, with random idle cycles ahead of it
    task automatic send_range(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_range_low  <= lo;
        s_range_high <= hi;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_counts.push_back(predict_prime_count(lo, hi));
    endtask

    // hold the sender until every expected count is back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // tiny bounds, bounds below two, bounds on squares of small primes
    task automatic test_small_bounds();
        send_range(0, 0);
        send_range(0, 1);
        send_range(1, 1);
        send_range(0, 2);
        send_range(2, 2);
        send_range(3, 3);
        send_range(4, 4);
        send_range(1, 3);
        send_range(0, 4);
        send_range(0, 25);
        send_range(25, 49);
        send_range(24, 26);
        send_range(0, 100);
        send_range(97, 97);
        send_range(1000, 1023);
    endtask

    // empty ranges: lower bound above upper, largest lower bound
    task automatic test_range_edges();
        send_range(50, 40);
        send_range(FIELD_MAX, 0);
        send_range(FIELD_MAX, 1023);
        send_range(2, 1);
        send_range(1023, 1022);
        send_range(20'd524288, 3);
        wait_results_drained();
    endtask

    // largest upper bound, whole table counted
    task automatic test_full_table();
        send_range(0, FIELD_MAX);
    endtask

    // random ranges, mostly small tables, some empty or degenerate
    task automatic test_random_ranges(input int n_items);
        int                 pick;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                hi = FIELD_W'($urandom_range(0, 1023));
            else if (pick < 92)
                hi = FIELD_W'($urandom_range(1024, 8191));
            else
                hi = FIELD_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: lo = FIELD_W'($urandom_range(0, 1));
                1: lo = FIELD_W'($urandom);
                2: lo = hi;
                default: lo = FIELD_W'($urandom_range(0, hi));
            endcase
            if ($urandom_range(0, 14) == 0)
                wait_results_drained();
            send_range(lo, hi);
        end
    endtask

    // main sequence
    initial begin
        build_prime_table();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(29, 77);
        test_small_bounds();
        test_range_edges();
        test_full_table();
        test_random_ranges(30);

        set_idling(77, 29);
        test_random_ranges(30);

        set_idling(0, 0);
        test_random_ranges(20);

        wait_results_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/spc_useq.sv
rtl/sieve_prime_counter.sv
bench/tb_top.sv
